@@ rtl/core/sorted_key_list_unit_macros.svh @@
// Assertion macros for the sorted key list unit.
// Needs a clock named clk and an active-low reset named arst_n in the including module.
`ifndef SORTED_KEY_LIST_UNIT_MACROS_SVH
`define SORTED_KEY_LIST_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define SKL_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define SKL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SKL_ASSERT(label, ante, cons, msg)
`define SKL_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

@@ rtl/core/skl_pkg.sv @@
// Shared types and codes for the sorted key list unit.
// No dependencies; used by skl_cell and sorted_key_list_unit.
package skl_pkg;

	// beat field widths
	localparam int KIND_W    = 2;
	localparam int KEY_W     = 32;
	localparam int STATUS_W  = 2;
	localparam int ENTRIES_W = 5;
	localparam int OUT_PAD_W = 1;
	localparam int OUT_W     = STATUS_W + ENTRIES_W + OUT_PAD_W;

	// operation codes on the input beat
	localparam logic [KIND_W-1:0] KIND_INS  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DEL  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SRCH = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_MISSING = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

	// controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_UPD
	} state_t;

	// update applied to every cell at once
	typedef enum logic [1:0] {
		OP_NOP,
		OP_INS,
		OP_DEL
	} cell_op_t;

	// broadcast control to the cell row
	typedef struct packed {
		logic     cmp;
		cell_op_t op;
	} cell_ctl_t;

endpackage

@@ rtl/core/sorted_key_list_unit.sv @@
// Sorted key list unit: top level with controller and a row of skl_cell slots.
// Depends on skl_pkg, skl_cell and sorted_key_list_unit_macros.svh.
//
// Keeps up to CAPACITY keys in ascending order (duplicates allowed, newest equal key
// ahead of older ones) in a row of cells. Each input beat inserts (kind 0), deletes
// (kind 1) or searches (kind 2, also kind 3) a key; each gives one result beat with a
// status (0 done/found, 1 not found, 2 empty, 3 full) and the key count afterward,
// modulo 32. An item passes through accept, a compare step in which every cell compares
// its key with the item's key in parallel, and an update step in which all cells shift at
// once and the result is loaded into the output register; the next beat is taken once the
// unit is back in idle. The update waits while an earlier result is not yet taken. Keys
// wider than KEY_BITS are truncated; a full store refuses inserts. No clearing after reset.
module sorted_key_list_unit #(
	parameter int CAPACITY = 16,
	parameter int KEY_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [skl_pkg::KEY_W-1:0]     s_tdata,  // [31:0] key
	input  logic [skl_pkg::KIND_W-1:0]    s_tuser,  // [1:0] kind
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [skl_pkg::OUT_W-1:0]     m_tdata   // [1:0] status, [6:2] entries, [7] zero
);
	import skl_pkg::*;
	`include "sorted_key_list_unit_macros.svh"

	localparam int CNT_W = $clog2(CAPACITY + 1);

	state_t                 state_q, state_d;
	logic [KIND_W-1:0]      kind_q;
	logic [KEY_BITS-1:0]    key_q;
	logic [CNT_W-1:0]       cnt_q, cnt_d;
	logic                   m_tvalid_q;
	logic [STATUS_W-1:0]    status_q, status_d;
	logic [ENTRIES_W-1:0]   entries_q;
	cell_op_t               op_d;
	cell_ctl_t              ctl;
	logic                   accept;
	logic                   apply;
	logic                   out_free;
	logic                   found;

	logic [KEY_BITS-1:0]    cell_key [CAPACITY];
	logic [CAPACITY-1:0]    cell_at;
	logic [CAPACITY-1:0]    cell_eq;

	assign out_free = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign found    = |cell_eq;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (s_tvalid) state_d = S_CMP;
			S_CMP:  state_d = S_UPD;
			S_UPD:  if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		s_tready = (state_q == S_IDLE);
		apply    = (state_q == S_UPD) && out_free;
		ctl.cmp  = (state_q == S_CMP);
		ctl.op   = apply ? op_d : OP_NOP;
	end

	// operation decision from the cell flags
	always_comb begin
		status_d = ST_OK;
		cnt_d    = cnt_q;
		op_d     = OP_NOP;
		case (kind_q)
			KIND_INS: begin
				if (cnt_q == CNT_W'(CAPACITY)) begin
					status_d = ST_FULL;
				end else begin
					op_d  = OP_INS;
					cnt_d = cnt_q + 1'b1;
				end
			end
			KIND_DEL: begin
				if (cnt_q == '0) begin
					status_d = ST_EMPTY;
				end else if (!found) begin
					status_d = ST_MISSING;
				end else begin
					op_d  = OP_DEL;
					cnt_d = cnt_q - 1'b1;
				end
			end
			default: status_d = found ? ST_OK : ST_MISSING;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (apply) begin
				cnt_q      <= cnt_d;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// item and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= s_tuser;
			key_q  <= KEY_BITS'(s_tdata);
		end
		if (apply) begin
			status_q  <= status_d;
			entries_q <= ENTRIES_W'(cnt_d);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{OUT_PAD_W{1'b0}}, entries_q, status_q};

	// row of cells, each wired to the neighbors it has
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [KEY_BITS-1:0] left_key;
		logic [KEY_BITS-1:0] right_key;
		logic                left_at;

		if (i == 0) begin : g_first
			assign left_key = key_q;
			assign left_at  = 1'b0;
		end else begin : g_mid
			assign left_key = cell_key[i-1];
			assign left_at  = cell_at[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_key = cell_key[i];
		end else begin : g_inner
			assign right_key = cell_key[i+1];
		end

		skl_cell #(
			.KEY_BITS (KEY_BITS),
			.CNT_W    (CNT_W),
			.IDX      (i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.key        (key_q),
			.cnt        (cnt_q),
			.left_key   (left_key),
			.left_at    (left_at),
			.right_key  (right_key),
			.stored_key (cell_key[i]),
			.at         (cell_at[i]),
			.eq         (cell_eq[i])
		);
	end

	// checks
	`SKL_ASSERT(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(CAPACITY), "count above capacity")
	`SKL_ASSERT_NEXT(a_cnt_hold, state_q != S_UPD, $stable(cnt_q), "count moved outside update")
	`SKL_ASSERT(a_full_stat, m_tvalid_q && status_q == ST_FULL, cnt_q == CNT_W'(CAPACITY), "full status while not full")
	`SKL_ASSERT(a_empty_stat, m_tvalid_q && status_q == ST_EMPTY, cnt_q == '0, "empty status while not empty")
	`SKL_ASSERT_NEXT(a_ins_grow, apply && op_d == OP_INS, cnt_q == $past(cnt_q) + 1'b1, "insert did not grow count")

endmodule

@@ rtl/core/skl_cell.sv @@
// One slot of the sorted key row: holds a key, compares it with the search key,
// and shifts toward either neighbor on insert or delete. Depends on skl_pkg.
module skl_cell #(
	parameter int KEY_BITS = 32,
	parameter int CNT_W    = 5,
	parameter int IDX      = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  skl_pkg::cell_ctl_t    ctl,
	input  logic [KEY_BITS-1:0]   key,
	input  logic [CNT_W-1:0]      cnt,
	input  logic [KEY_BITS-1:0]   left_key,
	input  logic                  left_at,
	input  logic [KEY_BITS-1:0]   right_key,
	output logic [KEY_BITS-1:0]   stored_key,
	output logic                  at,
	output logic                  eq
);
	import skl_pkg::*;

	localparam logic [CNT_W-1:0] MyIdx = CNT_W'(IDX);

	logic [KEY_BITS-1:0] stored_q;
	logic                at_q;
	logic                eq_q;
	logic                occupied;

	assign occupied = MyIdx < cnt;

	// compare phase: at = this slot is at or past the lower bound
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_q <= 1'b0;
			eq_q <= 1'b0;
		end else if (ctl.cmp) begin
			at_q <= !occupied || (stored_q >= key);
			eq_q <= occupied && (stored_q == key);
		end
	end

	// update phase: shift right on insert, left on delete
	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_INS: begin
				if (left_at)
					stored_q <= left_key;
				else if (at_q)
					stored_q <= key;
			end
			OP_DEL: begin
				if (at_q)
					stored_q <= right_key;
			end
			default: ;
		endcase
	end

	assign stored_key = stored_q;
	assign at         = at_q;
	assign eq         = eq_q;

endmodule

@@ tb/sorted_key_list_checker.sv @@
`timescale 1ns / 100ps
// Result checker for sorted_key_list_unit: watches both stream channels, tracks the sorted store.
// Depends on skl_pkg for field widths, operation codes and status codes.
module sorted_key_list_checker #(
	parameter int CAPACITY = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [skl_pkg::KEY_W-1:0]     s_tdata,
	input  logic [skl_pkg::KIND_W-1:0]    s_tuser,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [skl_pkg::OUT_W-1:0]     m_tdata,
	output int                            errors,
	output int                            outstanding
);
	import skl_pkg::*;

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [ENTRIES_W-1:0] entries;
	} outcome_t;

	// shadow of the store
	logic [KEY_W-1:0] stored_keys [CAPACITY];
	int               key_count;
	outcome_t         pending_outcomes [$];

	// apply one operation to the shadow store, return the outcome it gives
	function automatic outcome_t apply_op(input logic [KIND_W-1:0] op,
		input logic [KEY_W-1:0] k);
		outcome_t res;
		int       pos;
		logic     hit;
		pos = 0;
		while (pos < key_count && stored_keys[pos] < k)
			pos++;
		hit = (pos < key_count) && (stored_keys[pos] == k);
		case (op)
			KIND_INS: begin
				if (key_count >= CAPACITY) begin
					res.status = ST_FULL;
				end else begin
					for (int i = key_count; i > pos; i--)
						stored_keys[i] = stored_keys[i-1];
					stored_keys[pos] = k;
					key_count++;
					res.status = ST_OK;
				end
			end
			KIND_DEL: begin
				if (key_count == 0) begin
					res.status = ST_EMPTY;
				end else if (!hit) begin
					res.status = ST_MISSING;
				end else begin
					for (int i = pos; i + 1 < key_count; i++)
						stored_keys[i] = stored_keys[i+1];
					key_count--;
					res.status = ST_OK;
				end
			end
			// search, and the spare code behaves as search
			default: begin
				res.status = hit ? ST_OK : ST_MISSING;
			end
		endcase
		res.entries = ENTRIES_W'(key_count);
		return res;
	endfunction

	// compare result beats first: a beat in the same cycle belongs to an older item
	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		outcome_t got;
		int       bad;
		bad = 0;
		if (!arst_n) begin
			key_count = 0;
			pending_outcomes.delete();
			errors <= 0;
			outstanding <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.status  = m_tdata[STATUS_W-1:0];
				got.entries = m_tdata[STATUS_W +: ENTRIES_W];
				if (pending_outcomes.size() == 0) begin
					$display("%0t: unexpected result beat, status %0d entries %0d",
						$time, got.status, got.entries);
					bad++;
				end else begin
					want = pending_outcomes.pop_front();
					if (got.status !== want.status) begin
						$display("%0t: status mismatch, expected %0d, actual %0d",
							$time, want.status, got.status);
						bad++;
					end
					if (got.entries !== want.entries) begin
						$display("%0t: entries mismatch, expected %0d, actual %0d",
							$time, want.entries, got.entries);
						bad++;
					end
				end
			end
			if (s_tvalid && s_tready)
				pending_outcomes.push_back(apply_op(s_tuser, s_tdata));
			errors <= errors + bad;
			outstanding <= pending_outcomes.size();
		end
	end

endmodule

@@ tb/sorted_key_list_unit_test.sv @@
`timescale 1ns / 100ps
// Top of the sorted_key_list_unit testbench: clock, reset, stimulus, backpressure and verdict.
// Depends on skl_pkg, the unit itself and sorted_key_list_checker.
module sorted_key_list_unit_test;
	import skl_pkg::*;

	localparam int                CAPACITY   = 16;
	localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
	localparam int                POOL_SIZE  = 12;
	localparam int                BURST_LEN  = 30;
	localparam int                PHASE_LEN  = 200;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [KEY_W-1:0]     s_tdata;   // [31:0] key
	logic [KIND_W-1:0]    s_tuser;   // [1:0] kind
	logic                 m_tvalid;
	logic                 m_tready;
	logic [OUT_W-1:0]     m_tdata;   // [1:0] status, [6:2] entries, [7] zero
	int                   errors;
	int                   outstanding;

	int                   send_idle_pct;
	int                   recv_stall_pct;
	logic [KEY_W-1:0]     key_pool [POOL_SIZE];

	sorted_key_list_unit #(
		.CAPACITY(CAPACITY),
		.KEY_BITS(KEY_W)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	sorted_key_list_checker #(
		.CAPACITY(CAPACITY)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.errors(errors),
		.outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	initial begin
		#2ms;
		$display("Some tests failed");
		$finish;
	end

	// result side backpressure
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// one input beat, entered and left at a falling edge
	task automatic send_op(input logic [KIND_W-1:0] op, input logic [KEY_W-1:0] k);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= k;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// mostly keys from a small pool so deletes and searches hit
	function automatic logic [KEY_W-1:0] pick_key();
		if ($urandom_range(9) < 7)
			return key_pool[$urandom_range(POOL_SIZE-1)];
		return KEY_W'($urandom);
	endfunction

	// weighted kind: grow bursts favor inserts, shrink bursts favor deletes
	function automatic logic [KIND_W-1:0] pick_kind(input bit grow);
		int r;
		r = $urandom_range(9);
		if (r < 6)
			return grow ? KIND_INS : KIND_DEL;
		if (r < 8)
			return grow ? KIND_DEL : KIND_INS;
		return $urandom_range(1) ? KIND_SRCH : KIND_SPARE;
	endfunction

	initial begin
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tuser        = KIND_INS;
		arst_n         = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++)
			key_pool[i] = KEY_W'($urandom);
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: empty store, extreme keys, duplicates, spare kind, fill, full
		send_op(KIND_SRCH, 32'd5);
		send_op(KIND_DEL, 32'd5);
		send_op(KIND_INS, 32'hFFFF_FFFF);
		send_op(KIND_INS, 32'h0000_0000);
		send_op(KIND_INS, 32'd7);
		send_op(KIND_INS, 32'd7);
		send_op(KIND_SRCH, 32'd7);
		send_op(KIND_SRCH, 32'd8);
		send_op(KIND_SPARE, 32'h0000_0000);
		send_op(KIND_DEL, 32'd8);
		send_op(KIND_DEL, 32'd7);
		for (int i = 0; i < CAPACITY - 3; i++)
			send_op(KIND_INS, (i % 2) ? 32'hAAAA_AAAA - i : 32'h5555_5555 + i);
		send_op(KIND_INS, 32'd3);
		send_op(KIND_DEL, 32'hFFFF_FFFF);
		send_op(KIND_SRCH, 32'hFFFF_FFFF);

		// random phases: no idling, sender gaps, receiver stalls, both
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
				default: begin send_idle_pct = 13; recv_stall_pct = 13; end
			endcase
			for (int n = 0; n < PHASE_LEN; n++)
				send_op(pick_kind(((n / BURST_LEN) % 2) == 0), pick_key());
		end
		s_tvalid <= 1'b0;

		// drain, then allow the pipeline to settle
		while (outstanding != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0 && outstanding == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
